>>> hw/rtl/cbts_pkg.sv
// Shared types and constants for the CAN bit timing search block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package cbts_pkg;

  // Field widths
  localparam int unsigned CLK_W  = 30;
  localparam int unsigned BR_W   = 24;
  localparam int unsigned NQ_W   = 7;
  localparam int unsigned BRP_W  = 11;
  localparam int unsigned S1_W   = 9;
  localparam int unsigned S2_W   = 8;
  localparam int unsigned SP_W   = 7;
  localparam int unsigned ERRP_W = 10;
  localparam int unsigned STAT_W = 2;

  // Shared divider: full numerator width, short numerator width, divisor width, counter width
  localparam int unsigned DIV_NUM_W   = 37;
  localparam int unsigned DIV_SHORT_W = 31;
  localparam int unsigned DIV_DEN_W   = 31;
  localparam int unsigned DIV_CNT_W   = 6;

  // Bit timing constants
  localparam int unsigned T_SYNC    = 1;
  localparam int unsigned T_PROP    = 2;
  localparam int unsigned NQ_FLOOR  = 4;
  localparam int unsigned PCT_SCALE = 100;
  localparam int unsigned ERR_SAT   = 1000;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_EXACT  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_APPROX = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NONE   = 2'd2;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_NQ_MIN    = 3'd0;
  localparam logic [2:0] REG_NQ_MAX    = 3'd1;
  localparam logic [2:0] REG_BRP_MIN   = 3'd2;
  localparam logic [2:0] REG_BRP_MAX   = 3'd3;
  localparam logic [2:0] REG_TSEG1_MIN = 3'd4;
  localparam logic [2:0] REG_TSEG1_MAX = 3'd5;
  localparam logic [2:0] REG_TSEG2_MIN = 3'd6;
  localparam logic [2:0] REG_TSEG2_MAX = 3'd7;

  typedef struct packed {
    logic [NQ_W-1:0]  nq_min;
    logic [NQ_W-1:0]  nq_max;
    logic [BRP_W-1:0] brp_min;
    logic [BRP_W-1:0] brp_max;
    logic [S1_W-1:0]  tseg1_min;
    logic [S1_W-1:0]  tseg1_max;
    logic [S2_W-1:0]  tseg2_min;
    logic [S2_W-1:0]  tseg2_max;
  } cbts_cfg_t;

  typedef struct packed {
    logic                 start;
    logic                 wide;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } cbts_div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
  } cbts_div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/cbts_cfg_regs.sv
// APB-style register file holding the search limits.
// Depends on cbts_pkg for the register indexes and the cbts_cfg_t struct.
`default_nettype none

module cbts_cfg_regs
  import cbts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cbts_cfg_t   cfg
);

  cbts_cfg_t  cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nq_min    <= 7'd8;
      cfg_r.nq_max    <= 7'd25;
      cfg_r.brp_min   <= 11'd1;
      cfg_r.brp_max   <= 11'd1024;
      cfg_r.tseg1_min <= 9'd2;
      cfg_r.tseg1_max <= 9'd16;
      cfg_r.tseg2_min <= 8'd1;
      cfg_r.tseg2_max <= 8'd8;
    end else if (wr_en) begin
      case (idx)
        REG_NQ_MIN:    cfg_r.nq_min    <= pwdata[NQ_W-1:0];
        REG_NQ_MAX:    cfg_r.nq_max    <= pwdata[NQ_W-1:0];
        REG_BRP_MIN:   cfg_r.brp_min   <= pwdata[BRP_W-1:0];
        REG_BRP_MAX:   cfg_r.brp_max   <= pwdata[BRP_W-1:0];
        REG_TSEG1_MIN: cfg_r.tseg1_min <= pwdata[S1_W-1:0];
        REG_TSEG1_MAX: cfg_r.tseg1_max <= pwdata[S1_W-1:0];
        REG_TSEG2_MIN: cfg_r.tseg2_min <= pwdata[S2_W-1:0];
        REG_TSEG2_MAX: cfg_r.tseg2_max <= pwdata[S2_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_NQ_MIN:    prdata = 32'(cfg_r.nq_min);
      REG_NQ_MAX:    prdata = 32'(cfg_r.nq_max);
      REG_BRP_MIN:   prdata = 32'(cfg_r.brp_min);
      REG_BRP_MAX:   prdata = 32'(cfg_r.brp_max);
      REG_TSEG1_MIN: prdata = 32'(cfg_r.tseg1_min);
      REG_TSEG1_MAX: prdata = 32'(cfg_r.tseg1_max);
      REG_TSEG2_MIN: prdata = 32'(cfg_r.tseg2_min);
      REG_TSEG2_MAX: prdata = 32'(cfg_r.tseg2_max);
      default:       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/cbts_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on cbts_pkg for widths and the request/response structs.
`default_nettype none

module cbts_div
  import cbts_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cbts_div_req_t req,
  output cbts_div_rsp_t rsp
);

  localparam int unsigned PAD_W = DIV_NUM_W - DIV_SHORT_W;

  logic [DIV_NUM_W-1:0] acc_r, acc_nxt;
  logic [DIV_DEN_W-1:0] rem_r, rem_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_DEN_W:0]   rem_sh;
  logic [DIV_DEN_W+1:0] diff;
  logic                 take;

  // Shift the next numerator bit into the partial remainder and trial-subtract
  always_comb begin
    rem_sh  = {rem_r, acc_r[DIV_NUM_W-1]};
    diff    = {1'b0, rem_sh} - {2'b0, den_r};
    take    = !diff[DIV_DEN_W+1];
    rem_nxt = take ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    acc_nxt = {acc_r[DIV_NUM_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.wide ? DIV_CNT_W'(DIV_NUM_W) : DIV_CNT_W'(DIV_SHORT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Short operands are left-aligned so the quotient always lands in the low bits
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= req.wide ? req.num : {req.num[DIV_SHORT_W-1:0], {PAD_W{1'b0}}};
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = acc_r;

endmodule

`default_nettype wire

>>> hw/rtl/can_bit_timing_search_core.sv
// CAN bit timing search: given a clock frequency and a target bitrate, walk the
// quanta counts nq_min..nq_max, round a prescaler for each, check it and the
// derived segments against the programmed limits, and keep the count with the
// strictly smallest bitrate error (stop at once on an exact hit). One input beat
// yields one result beat. All divisions go through one shared restoring divider
// that produces one quotient bit per cycle, so the search time follows the number
// of divisions: a count rejected on its segments needs none, one rejected on its
// prescaler needs one, a count that reaches the error compare needs two; when a
// setting is found, the sample point and error percent divisions come before
// hand-off. The worst case walks 124 counts, all fully evaluated.
// Input ready is high only while the sequencer is idle; a finished result sits
// in the output register and does not block the next input beat.
// Depends on cbts_pkg, cbts_cfg_regs and cbts_div.
`default_nettype none

module can_bit_timing_search_core
  import cbts_pkg::*;
#(
  parameter int unsigned SJW_MIN = 1,
  parameter int unsigned SJW_MAX = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CLK_W-1:0]     in_clock_hz,
  input  logic [BR_W-1:0]      in_bitrate,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [NQ_W-1:0]      out_quanta,
  output logic [BRP_W-1:0]     out_prescaler,
  output logic [S1_W-1:0]      out_seg_one,
  output logic [S2_W-1:0]      out_seg_two,
  output logic [S2_W-1:0]      out_jump_width,
  output logic [SP_W-1:0]      out_sample_point_pct,
  output logic [ERRP_W-1:0]    out_error_pct
);

  localparam logic [S2_W-1:0] SJW_LO = S2_W'(SJW_MIN);
  localparam logic [S2_W-1:0] SJW_HI = S2_W'(SJW_MAX);

  // Sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;  // wait for an input beat
  localparam logic [3:0] ST_NQ   = 4'd1;  // range and segment check of one count
  localparam logic [3:0] ST_D1   = 4'd2;  // start prescaler division
  localparam logic [3:0] ST_W1   = 4'd3;  // wait prescaler, check limits
  localparam logic [3:0] ST_D2   = 4'd4;  // start actual bitrate division
  localparam logic [3:0] ST_W2   = 4'd5;  // wait actual bitrate, compare error
  localparam logic [3:0] ST_FIN  = 4'd6;  // start sample point division
  localparam logic [3:0] ST_WSP  = 4'd7;  // wait sample point, start error percent
  localparam logic [3:0] ST_WERR = 4'd8;  // wait error percent
  localparam logic [3:0] ST_OUT  = 4'd9;  // hand result to the output register

  cbts_cfg_t     cfg;
  cbts_div_req_t div_req;
  cbts_div_rsp_t div_rsp;

  logic [3:0]           state_r;
  logic [CLK_W-1:0]     clk_hz_r;
  logic [BR_W-1:0]      br_r;
  logic [NQ_W:0]        nq_r;      // one bit wider so nq_max = 127 terminates
  logic [DIV_DEN_W-1:0] prod_r;    // current divisor, quanta times bitrate or prescaler
  logic [S1_W-1:0]      cand_s1_r;
  logic [S2_W-1:0]      cand_s2_r;
  logic [BRP_W-1:0]     cand_brp_r;

  // Best candidate so far
  logic                 found_r;
  logic [DIV_DEN_W-1:0] best_r;
  logic [NQ_W-1:0]      b_nq_r;
  logic [BRP_W-1:0]     b_brp_r;
  logic [S1_W-1:0]      b_s1_r;
  logic [S2_W-1:0]      b_s2_r;
  logic [SP_W-1:0]      b_sp_r;
  logic [ERRP_W-1:0]    b_errp_r;

  // Output register
  logic                 out_valid_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [NQ_W-1:0]      out_quanta_r;
  logic [BRP_W-1:0]     out_prescaler_r;
  logic [S1_W-1:0]      out_seg_one_r;
  logic [S2_W-1:0]      out_seg_two_r;
  logic [S2_W-1:0]      out_jump_width_r;
  logic [SP_W-1:0]      out_sp_r;
  logic [ERRP_W-1:0]    out_errp_r;

  // Per-count segment arithmetic
  logic [NQ_W-1:0]      tseg_c;
  logic [S2_W-1:0]      half_c;
  logic [S2_W-1:0]      s2_c;
  logic [S2_W-1:0]      lim_c;
  logic [S1_W-1:0]      s1_c;
  logic                 seg_ok;
  logic                 nq_done;
  logic [DIV_DEN_W-1:0] prod_br_c;

  // Division results
  logic [DIV_SHORT_W-1:0] rnd_num_c;
  logic [DIV_DEN_W-1:0]   quo_short;
  logic                   brp_ok;
  logic [DIV_DEN_W-1:0]   prod_brp_c;
  logic [DIV_DEN_W-1:0]   br_ext;
  logic [DIV_DEN_W-1:0]   err_c;
  logic                   better;
  logic [15:0]            sp_num_c;
  logic [DIV_NUM_W-1:0]   err_num_c;
  logic [S2_W-1:0]        sjw_c;
  logic                   out_load;

  cbts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cbts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Segment split: sync and propagation come off the top, segment two is
  // half of the remainder clamped, segment one takes the rest plus propagation.
  always_comb begin
    tseg_c  = nq_r[NQ_W-1:0] - NQ_W'(T_SYNC + T_PROP);
    half_c  = S2_W'(tseg_c[NQ_W-1:1]);
    if (half_c < cfg.tseg2_min) begin
      s2_c = cfg.tseg2_min;
    end else if (half_c > cfg.tseg2_max) begin
      s2_c = cfg.tseg2_max;
    end else begin
      s2_c = half_c;
    end
    lim_c   = S2_W'(tseg_c) + S2_W'(T_PROP);
    s1_c    = S1_W'(lim_c) - S1_W'(s2_c);
    nq_done = nq_r > {1'b0, cfg.nq_max};
    seg_ok  = (nq_r >= (NQ_W+1)'(NQ_FLOOR)) && (s2_c <= lim_c) &&
              (s1_c >= cfg.tseg1_min) && (s1_c <= cfg.tseg1_max);
    prod_br_c = DIV_DEN_W'(nq_r[NQ_W-1:0]) * DIV_DEN_W'(br_r);
  end

  // Prescaler check and actual bitrate error from the divider result
  always_comb begin
    quo_short  = div_rsp.quo[DIV_DEN_W-1:0];
    brp_ok     = (quo_short != '0) &&
                 (quo_short >= DIV_DEN_W'(cfg.brp_min)) &&
                 (quo_short <= DIV_DEN_W'(cfg.brp_max));
    prod_brp_c = DIV_DEN_W'(nq_r[NQ_W-1:0]) * DIV_DEN_W'(quo_short[BRP_W-1:0]);
    br_ext     = DIV_DEN_W'(br_r);
    err_c      = (br_ext >= quo_short) ? (br_ext - quo_short) : (quo_short - br_ext);
    better     = !found_r || (err_c < best_r);
  end

  // Round-to-nearest numerators: add half the divisor before dividing
  always_comb begin
    rnd_num_c = DIV_SHORT_W'(clk_hz_r) + DIV_SHORT_W'(prod_r[DIV_DEN_W-1:1]);
    sp_num_c  = (16'(b_s1_r) + 16'(T_SYNC)) * 16'(PCT_SCALE) + 16'(b_nq_r[NQ_W-1:1]);
    err_num_c = DIV_NUM_W'(best_r) * DIV_NUM_W'(PCT_SCALE) +
                DIV_NUM_W'(br_r[BR_W-1:1]);
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state_r)
      ST_D1, ST_D2: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_NUM_W'(rnd_num_c);
        div_req.den   = prod_r;
      end
      ST_FIN: begin
        div_req.start = found_r;
        div_req.num   = DIV_NUM_W'(sp_num_c);
        div_req.den   = DIV_DEN_W'(b_nq_r);
      end
      ST_WSP: begin
        div_req.start = div_rsp.done;
        div_req.wide  = 1'b1;
        div_req.num   = err_num_c;
        div_req.den   = DIV_DEN_W'(br_r);
      end
      default: ;
    endcase
  end

  // Jump width: segment two clamped to the fixed limits
  always_comb begin
    if (b_s2_r < SJW_LO) begin
      sjw_c = SJW_LO;
    end else if (b_s2_r > SJW_HI) begin
      sjw_c = SJW_HI;
    end else begin
      sjw_c = b_s2_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Sequencer and candidate bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            clk_hz_r <= in_clock_hz;
            br_r     <= in_bitrate;
            nq_r     <= {1'b0, cfg.nq_min};
            found_r  <= 1'b0;
            best_r   <= '0;
            // zero bitrate can never produce a valid setting
            state_r  <= (in_bitrate == '0) ? ST_FIN : ST_NQ;
          end
        end
        ST_NQ: begin
          if (nq_done) begin
            state_r <= ST_FIN;
          end else if (seg_ok) begin
            cand_s1_r <= s1_c;
            cand_s2_r <= s2_c;
            prod_r    <= prod_br_c;
            state_r   <= ST_D1;
          end else begin
            nq_r <= nq_r + 1'b1;
          end
        end
        ST_D1: begin
          state_r <= ST_W1;
        end
        ST_W1: begin
          if (div_rsp.done) begin
            if (brp_ok) begin
              cand_brp_r <= quo_short[BRP_W-1:0];
              prod_r     <= prod_brp_c;
              state_r    <= ST_D2;
            end else begin
              nq_r    <= nq_r + 1'b1;
              state_r <= ST_NQ;
            end
          end
        end
        ST_D2: begin
          state_r <= ST_W2;
        end
        ST_W2: begin
          if (div_rsp.done) begin
            nq_r    <= nq_r + 1'b1;
            state_r <= ST_NQ;
            if (better) begin
              found_r <= 1'b1;
              best_r  <= err_c;
              b_nq_r  <= nq_r[NQ_W-1:0];
              b_brp_r <= cand_brp_r;
              b_s1_r  <= cand_s1_r;
              b_s2_r  <= cand_s2_r;
              // exact hit: stop the walk
              if (err_c == '0) begin
                state_r <= ST_FIN;
              end
            end
          end
        end
        ST_FIN: begin
          state_r <= found_r ? ST_WSP : ST_OUT;
        end
        ST_WSP: begin
          if (div_rsp.done) begin
            b_sp_r  <= div_rsp.quo[SP_W-1:0];
            state_r <= ST_WERR;
          end
        end
        ST_WERR: begin
          if (div_rsp.done) begin
            b_errp_r <= (div_rsp.quo > DIV_NUM_W'(ERR_SAT)) ? ERRP_W'(ERR_SAT)
                                                           : div_rsp.quo[ERRP_W-1:0];
            state_r  <= ST_OUT;
          end
        end
        ST_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register: load a fresh result, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (found_r) begin
        out_status_r     <= (best_r == '0) ? STATUS_EXACT : STATUS_APPROX;
        out_quanta_r     <= b_nq_r;
        out_prescaler_r  <= b_brp_r;
        out_seg_one_r    <= b_s1_r;
        out_seg_two_r    <= b_s2_r;
        out_jump_width_r <= sjw_c;
        out_sp_r         <= b_sp_r;
        out_errp_r       <= b_errp_r;
      end else begin
        out_status_r     <= STATUS_NONE;
        out_quanta_r     <= '0;
        out_prescaler_r  <= '0;
        out_seg_one_r    <= '0;
        out_seg_two_r    <= '0;
        out_jump_width_r <= '0;
        out_sp_r         <= '0;
        out_errp_r       <= '0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_quanta           = out_quanta_r;
  assign out_prescaler        = out_prescaler_r;
  assign out_seg_one          = out_seg_one_r;
  assign out_seg_two          = out_seg_two_r;
  assign out_jump_width       = out_jump_width_r;
  assign out_sample_point_pct = out_sp_r;
  assign out_error_pct        = out_errp_r;

endmodule

`default_nettype wire

>>> hw/rtl/cbts_checker.sv
// Port-level checks for the CAN bit timing search block, bound to its top level.
// Depends on cbts_pkg for status codes and widths.
`default_nettype none

module cbts_checker
  import cbts_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [NQ_W-1:0]   out_quanta,
  input logic [BRP_W-1:0]  out_prescaler,
  input logic [ERRP_W-1:0] out_error_pct
);

  // A waiting result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_quanta) && $stable(out_prescaler) && $stable(out_error_pct))
    else $error("result beat changed while stalled");

  // One item at a time: ready drops right after an input beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a search is running");

  // No setting found: quanta, prescaler and error percent read zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NONE) |-> (out_quanta == '0) &&
    (out_prescaler == '0) && (out_error_pct == '0))
    else $error("non-zero fields with no valid setting");

  // Exact result carries zero error, a real prescaler and non-zero quanta
  a_exact_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_EXACT) |-> (out_error_pct == '0) &&
    (out_prescaler != '0) && (out_quanta != '0))
    else $error("exact status with error or empty setting");

endmodule

bind can_bit_timing_search_core cbts_checker u_cbts_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_quanta    (out_quanta),
  .out_prescaler (out_prescaler),
  .out_error_pct (out_error_pct)
);

`default_nettype wire
